// ----- rtl/core/signed_int_to_decimal_ascii_defines.svh -----
// Assertion macros for the digit engine of the signed integer to decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define SITD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SITD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sitd_pkg.sv -----
// Types, constants and the power-of-ten table for the decimal text converter.
package sitd_pkg;

   localparam int unsigned MAG_WIDTH = 32;
   localparam int unsigned SCALED_WIDTH = 34;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [3:0] LAST_POS   = 4'd9;
   localparam logic [3:0] MAX_CHARS  = 4'd11;

   typedef struct packed {
      logic                 negative;
      logic [MAG_WIDTH-1:0] magnitude;
      logic                 stream_select;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // k times the power of ten that weights digit position pos (position 0 is 10^9)
   function automatic logic [SCALED_WIDTH-1:0] scaled_power(input logic [3:0] pos,
                                                           input logic [3:0] k);
      logic [63:0] p;
      case (pos)
         4'd0:    p = 64'd1000000000;
         4'd1:    p = 64'd100000000;
         4'd2:    p = 64'd10000000;
         4'd3:    p = 64'd1000000;
         4'd4:    p = 64'd100000;
         4'd5:    p = 64'd10000;
         4'd6:    p = 64'd1000;
         4'd7:    p = 64'd100;
         4'd8:    p = 64'd10;
         default: p = 64'd1;
      endcase
      return SCALED_WIDTH'(p * {60'd0, k});
   endfunction

endpackage

// ----- rtl/core/sitd_front.sv -----
// Front end: accept an item, split it into sign and magnitude, push it.
module sitd_front (
   input  logic                       start,
   output logic                       busy,
   input  logic signed [31:0]         req_value,
   input  logic                       req_to_error_stream,
   input  sitd_pkg::queue_status_type status,
   output logic                       push,
   output sitd_pkg::item_type         wr_item
);

   logic [31:0] value_bits;

   assign value_bits = $unsigned(req_value);
   assign busy       = status.full;
   assign push       = start && !status.full;

   always_comb begin
      wr_item.negative      = value_bits[31];
      wr_item.magnitude     = value_bits[31] ? (~value_bits + 32'd1) : value_bits;
      wr_item.stream_select = req_to_error_stream;
   end

endmodule

// ----- rtl/core/sitd_queue.sv -----
// Two-entry item queue between the front end and the digit engine.
module sitd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sitd_pkg::item_type         wr_item,
   input  logic                       pop,
   output sitd_pkg::item_type         rd_item,
   output sitd_pkg::queue_status_type status
);

   sitd_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign rd_item      = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- rtl/core/sitd_back.sv -----
// Digit engine: one sign or digit step per cycle, registered character output.
`include "signed_int_to_decimal_ascii_defines.svh"

module sitd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sitd_pkg::queue_status_type status,
   input  sitd_pkg::item_type         rd_item,
   output logic                       pop,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_char_code,
   output logic                       rsp_stream_select,
   output logic                       rsp_last_char,
   output logic [3:0]                 rsp_char_total
);

   logic        active_ff, active_in;
   logic        neg_pend_ff, neg_pend_in;
   logic        started_ff, started_in;
   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] mag_ff, mag_in;
   logic        sel_ff, sel_in;

   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        out_sel_ff;
   logic        last_ff, last_in;
   logic [3:0]  total_ff, total_in;

   logic [8:0]  reached;
   logic [3:0]  digit;
   logic [sitd_pkg::SCALED_WIDTH-1:0] subtrahend;
   logic [31:0] remainder;
   logic        emit_digit;
   logic        finishing;

   always_comb begin
      subtrahend = '0;
      for (int k = 1; k <= 9; k++) begin
         reached[k-1] = {2'b00, mag_ff} >= sitd_pkg::scaled_power(pos_ff, 4'(k));
         if (reached[k-1]) begin
            subtrahend = sitd_pkg::scaled_power(pos_ff, 4'(k));
         end
      end
      digit      = 4'($countones(reached));
      remainder  = mag_ff - subtrahend[31:0];
      emit_digit = (digit != 4'd0) || started_ff || (pos_ff == sitd_pkg::LAST_POS);
      finishing  = active_ff && !neg_pend_ff && (pos_ff == sitd_pkg::LAST_POS);
      pop        = !status.empty && (!active_ff || finishing);
   end

   always_comb begin
      active_in   = active_ff;
      neg_pend_in = neg_pend_ff;
      started_in  = started_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      mag_in      = mag_ff;
      sel_in      = sel_ff;

      valid_in = active_ff && (neg_pend_ff || emit_digit);
      char_in  = neg_pend_ff ? sitd_pkg::CHAR_MINUS : (sitd_pkg::CHAR_ZERO + {4'd0, digit});
      last_in  = finishing;
      total_in = finishing ? (count_ff + 4'd1) : 4'd0;

      if (active_ff) begin
         if (neg_pend_ff) begin
            neg_pend_in = 1'b0;
            count_in    = count_ff + 4'd1;
         end else begin
            mag_in = remainder;
            pos_in = pos_ff + 4'd1;
            if (emit_digit) begin
               started_in = 1'b1;
               count_in   = count_ff + 4'd1;
            end
            if (finishing) begin
               active_in = 1'b0;
            end
         end
      end

      if (pop) begin
         active_in   = 1'b1;
         neg_pend_in = rd_item.negative;
         started_in  = 1'b0;
         pos_in      = 4'd0;
         count_in    = 4'd0;
         mag_in      = rd_item.magnitude;
         sel_in      = rd_item.stream_select;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_pend_ff <= neg_pend_in;
      started_ff  <= started_in;
      pos_ff      <= pos_in;
      count_ff    <= count_in;
      mag_ff      <= mag_in;
      sel_ff      <= sel_in;
      char_ff     <= char_in;
      out_sel_ff  <= sel_ff;
      last_ff     <= last_in;
      total_ff    <= total_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_char_code     = char_ff;
   assign rsp_stream_select = out_sel_ff;
   assign rsp_last_char     = last_ff;
   assign rsp_char_total    = total_ff;

   `SITD_ASSERT_NOW(a_total_on_last, clock, reset, valid_ff && last_ff,
      (total_ff != 4'd0) && (total_ff <= sitd_pkg::MAX_CHARS), "bad total on last character")
   `SITD_ASSERT_NOW(a_total_zero_mid, clock, reset, valid_ff && !last_ff,
      total_ff == 4'd0, "nonzero total before last character")
   `SITD_ASSERT_NOW(a_char_legal, clock, reset, valid_ff,
      (char_ff == sitd_pkg::CHAR_MINUS) || ((char_ff >= 8'h30) && (char_ff <= 8'h39)),
      "illegal character code")
   `SITD_ASSERT_NOW(a_pos_range, clock, reset, active_ff,
      pos_ff <= sitd_pkg::LAST_POS, "digit position out of range")
   `SITD_ASSERT_NEXT(a_load_starts, clock, reset, pop,
      active_ff && (pos_ff == 4'd0) && (count_ff == 4'd0), "load did not start a run")

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// Signed 32-bit integer to decimal ASCII text, one character per strobe.
// When idle, a taken item is loaded from the queue into the digit engine and its '-' or tenth-place
// digit is registered onto the output; each suppressed leading zero is a digit step with no strobe.
// A sign step if negative, then one digit position per cycle; the next item loads as the last ends.
// Receiver cannot stall; a two-entry queue takes start while the digit engine works, until full.
// Reset is synchronous and clears the queue, the engine and the output strobe.
module signed_int_to_decimal_ascii (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_value,
   input  logic               req_to_error_stream,
   output logic               rsp_valid,
   output logic [7:0]         rsp_char_code,
   output logic               rsp_stream_select,
   output logic               rsp_last_char,
   output logic [3:0]         rsp_char_total
);

   sitd_pkg::queue_status_type status;
   sitd_pkg::item_type         wr_item;
   sitd_pkg::item_type         rd_item;
   logic                       push;
   logic                       pop;

   sitd_front u_front (
      .start               (start),
      .busy                (busy),
      .req_value           (req_value),
      .req_to_error_stream (req_to_error_stream),
      .status              (status),
      .push                (push),
      .wr_item             (wr_item)
   );

   sitd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (wr_item),
      .pop     (pop),
      .rd_item (rd_item),
      .status  (status)
   );

   sitd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .status            (status),
      .rd_item           (rd_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_char_code     (rsp_char_code),
      .rsp_stream_select (rsp_stream_select),
      .rsp_last_char     (rsp_last_char),
      .rsp_char_total    (rsp_char_total)
   );

endmodule

// ----- verif/tb_signed_int_to_decimal_ascii.sv -----
// Testbench for signed_int_to_decimal_ascii: directed and random numbers, text checked per char.
module tb_signed_int_to_decimal_ascii;

   typedef struct {
      logic signed [31:0] value;
      logic               to_err;
      int                 gap;
      bit                 drain_first;
   } number_type;

   typedef struct {
      logic [7:0] char_code;
      logic       stream_select;
      logic       last_char;
      logic [3:0] char_total;
   } text_char_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_value = '0;
   logic               req_to_error_stream = 1'b0;
   logic               rsp_valid;
   logic [7:0]         rsp_char_code;
   logic               rsp_stream_select;
   logic               rsp_last_char;
   logic [3:0]         rsp_char_total;

   number_type    numbers_to_send[$];
   text_char_type text_chars[$];
   int            mismatch_count = 0;
   int            gap_left = -1;
   int            numbers_made = 0;

   signed_int_to_decimal_ascii u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_value           (req_value),
      .req_to_error_stream (req_to_error_stream),
      .rsp_valid           (rsp_valid),
      .rsp_char_code       (rsp_char_code),
      .rsp_stream_select   (rsp_stream_select),
      .rsp_last_char       (rsp_last_char),
      .rsp_char_total      (rsp_char_total)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void render_decimal(logic signed [31:0] value, logic sel);
      logic [31:0]   mag;
      logic [7:0]    digits [10];
      int            n_digits;
      int            total;
      text_char_type c;
      mag = value[31] ? (~value + 32'd1) : value;
      n_digits = 0;
      do begin
         digits[n_digits] = sitd_pkg::CHAR_ZERO + 8'(mag % 32'd10);
         mag = mag / 32'd10;
         n_digits++;
      end while (mag != 0);
      total = n_digits + (value[31] ? 1 : 0);
      c.stream_select = sel;
      if (value[31]) begin
         c.char_code = sitd_pkg::CHAR_MINUS;
         c.last_char = 1'b0;
         c.char_total = 4'd0;
         text_chars.push_back(c);
      end
      for (int i = n_digits - 1; i >= 0; i--) begin
         c.char_code = digits[i];
         c.last_char = (i == 0);
         c.char_total = (i == 0) ? 4'(total) : 4'd0;
         text_chars.push_back(c);
      end
   endfunction

   function automatic void add_number(logic signed [31:0] value, logic sel, bit drain_first,
                                      bit no_gap);
      number_type n;
      n.value = value;
      n.to_err = sel;
      n.gap = no_gap ? 0 : int'($urandom_range(0, 9));
      n.drain_first = drain_first;
      numbers_to_send.push_back(n);
      numbers_made++;
   endfunction

   // driver
   always @(posedge clock) begin
      logic next_start;
      if (reset) begin
         start <= 1'b0;
         req_value <= '0;
         req_to_error_stream <= 1'b0;
         gap_left = -1;
      end else begin
         next_start = start;
         if (start && !busy) begin
            render_decimal(req_value, req_to_error_stream);
            void'(numbers_to_send.pop_front());
            next_start = 1'b0;
            gap_left = -1;
         end
         if (!next_start && numbers_to_send.size() > 0) begin
            if (gap_left < 0) gap_left = numbers_to_send[0].gap;
            if (numbers_to_send[0].drain_first && text_chars.size() != 0) begin
               // hold until all text is out
            end else if (gap_left > 0) begin
               gap_left--;
            end else begin
               next_start = 1'b1;
               req_value <= numbers_to_send[0].value;
               req_to_error_stream <= numbers_to_send[0].to_err;
            end
         end
         start <= next_start;
      end
   end

   // monitor
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid) begin
         if (text_chars.size() == 0) begin
            $display("%0t: expected no char, actual code=%h sel=%b last=%b total=%0d", $time,
                     rsp_char_code, rsp_stream_select, rsp_last_char, rsp_char_total);
            mismatch_count++;
         end else begin
            want = text_chars.pop_front();
            if (rsp_char_code !== want.char_code) begin
               $display("%0t: char_code expected %h actual %h", $time, want.char_code,
                        rsp_char_code);
               mismatch_count++;
            end
            if (rsp_stream_select !== want.stream_select) begin
               $display("%0t: stream_select expected %b actual %b", $time,
                        want.stream_select, rsp_stream_select);
               mismatch_count++;
            end
            if (rsp_last_char !== want.last_char) begin
               $display("%0t: last_char expected %b actual %b", $time, want.last_char,
                        rsp_last_char);
               mismatch_count++;
            end
            if (rsp_char_total !== want.char_total) begin
               $display("%0t: char_total expected %0d actual %0d", $time, want.char_total,
                        rsp_char_total);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      logic signed [31:0] directed [$];
      logic signed [31:0] v;
      logic [31:0]        p;
      bit                 no_gap;
      directed = {32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd2147483647,
                  $signed(32'h80000000), -32'sd2147483647, 32'sd1000000000, 32'sd999999999,
                  -32'sd999999999, 32'sd1000000001, 32'sd100, -32'sd5, 32'sd123456789,
                  -32'sd1000000000, 32'sd2000000000, 32'sd5, -32'sd100};
      foreach (directed[i]) add_number(directed[i], 1'(i % 2), 1'b0, 1'b0);
      add_number(32'sd42, 1'b1, 1'b1, 1'b0);
      while (numbers_made < 410) begin
         no_gap = ((numbers_made / 20) % 3) == 0;
         case ($urandom_range(0, 3))
            0: v = $signed($urandom());
            1: v = $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
            2: begin
               p = 32'd1;
               repeat ($urandom_range(0, 9)) p = p * 32'd10;
               v = $signed(p) + $signed(32'($urandom_range(0, 2))) - 32'sd1;
               if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $signed(32'($urandom_range(0, 99999))) *
                         ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
         endcase
         add_number(v, 1'($urandom_range(0, 1)), (numbers_made % 50) == 0, no_gap);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (numbers_to_send.size() != 0 || text_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && text_chars.size() == 0) begin
         $display("[signed_int_to_decimal_ascii] OK");
      end else begin
         $display("[signed_int_to_decimal_ascii] ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[signed_int_to_decimal_ascii] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sitd_pkg.sv
rtl/core/sitd_front.sv
rtl/core/sitd_queue.sv
rtl/core/sitd_back.sv
rtl/core/signed_int_to_decimal_ascii.sv
verif/tb_signed_int_to_decimal_ascii.sv
